[design/itrd_pkg.sv]
// ----------------------------------------------------------------------------
// itrd_pkg: shared constants, types and functions
// Widths, digit store geometry and the ASCII glyph table for the radix
// converter.
// ----------------------------------------------------------------------------
package itrd_pkg;

	localparam int ITRD_VALUE_WIDTH = 64;
	localparam int VALUE_FIELD_W    = 64;
	localparam int RADIX_W          = 5;
	localparam int DIGIT_W          = 4;
	localparam int CHAR_W           = 7;
	localparam int STORE_DEPTH      = 64;
	localparam int ADDR_W           = $clog2(STORE_DEPTH);
	localparam int CNT_W            = ADDR_W + 1;
	localparam int STEPS_PER_CYCLE  = 8;
	localparam int Q_DEPTH          = 2;

	localparam logic [RADIX_W-1:0] RADIX_RESET = RADIX_W'(10);
	localparam logic [RADIX_W-1:0] RADIX_MIN   = RADIX_W'(2);
	localparam logic [RADIX_W-1:0] RADIX_MAX   = RADIX_W'(16);

	localparam logic [CHAR_W-1:0] GLYPHS [16] = '{
		7'h30, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36, 7'h37,
		7'h38, 7'h39, 7'h41, 7'h42, 7'h43, 7'h44, 7'h45, 7'h46
	};

	// Queue status seen by both sides
	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

	function automatic logic [CHAR_W-1:0] glyph(input logic [DIGIT_W-1:0] d);
		return GLYPHS[d];
	endfunction

endpackage

[design/itrd_front.sv]
// ----------------------------------------------------------------------------
// itrd_front: command front end
// Holds the radix register, accepts items, saturates the base, masks the
// value and flags zero, then pushes the classified item into the queue.
// ----------------------------------------------------------------------------
module itrd_front
	import itrd_pkg::*;
#(
	parameter int VALUE_WIDTH = ITRD_VALUE_WIDTH
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [VALUE_FIELD_W-1:0]     value,
	input  logic                         radix_we,
	input  logic [RADIX_W-1:0]           radix_wdata,
	input  q_stat_t                      q_stat,
	output logic                         busy,
	output logic                         push,
	output logic [VALUE_WIDTH+RADIX_W:0] push_data
);

	logic [RADIX_W-1:0]     radix_q;
	logic [RADIX_W-1:0]     base;
	logic [VALUE_WIDTH-1:0] masked;
	logic                   is_zero;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radix_q <= RADIX_RESET;
		end else if (radix_we) begin
			radix_q <= radix_wdata;
		end
	end

	always_comb begin
		priority if (radix_q < RADIX_MIN) begin
			base = RADIX_MIN;
		end else if (radix_q > RADIX_MAX) begin
			base = RADIX_MAX;
		end else begin
			base = radix_q;
		end
	end

	assign masked    = value[VALUE_WIDTH-1:0];
	assign is_zero   = (masked == '0);
	assign busy      = q_stat.full;
	assign push      = start && !q_stat.full;
	assign push_data = {is_zero, base, masked};

endmodule

[design/itrd_queue.sv]
// ----------------------------------------------------------------------------
// itrd_queue: short command queue
// Small FIFO between front end and conversion engine.
// ----------------------------------------------------------------------------
module itrd_queue
	import itrd_pkg::*;
#(
	parameter int WIDTH = ITRD_VALUE_WIDTH + RADIX_W + 1
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	input  logic             pop,
	output logic [WIDTH-1:0] pop_data,
	output q_stat_t          q_stat
);

	localparam int PTR_W = $clog2(Q_DEPTH);
	localparam int QC_W  = PTR_W + 1;

	logic [WIDTH-1:0] slot_q [Q_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [QC_W-1:0]  count_q;
	logic             do_push;
	logic             do_pop;

	assign do_push = push && (count_q != QC_W'(Q_DEPTH));
	assign do_pop  = pop && (count_q != '0);

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + PTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			end
			unique case ({do_push, do_pop})
				2'b10:   count_q <= count_q + QC_W'(1);
				2'b01:   count_q <= count_q - QC_W'(1);
				default: count_q <= count_q;
			endcase
		end
	end

	assign pop_data     = slot_q[rd_ptr_q];
	assign q_stat.full  = (count_q == QC_W'(Q_DEPTH));
	assign q_stat.empty = (count_q == '0);

endmodule

[design/itrd_back.sv]
// ----------------------------------------------------------------------------
// itrd_back: conversion engine
// Divides by the base eight quotient bits a cycle, stores each remainder,
// then streams the stored digits out most significant first as ASCII.
// ----------------------------------------------------------------------------
module itrd_back
	import itrd_pkg::*;
#(
	parameter int VALUE_WIDTH = ITRD_VALUE_WIDTH
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  q_stat_t                      q_stat,
	input  logic [VALUE_WIDTH+RADIX_W:0] pop_data,
	output logic                         pop,
	output logic                         strobe,
	output logic [CHAR_W-1:0]            char_code,
	output logic                         last
);

	localparam int DIV_W   = ((VALUE_WIDTH + STEPS_PER_CYCLE - 1) / STEPS_PER_CYCLE)
	                         * STEPS_PER_CYCLE;
	localparam int DIV_CYC = DIV_W / STEPS_PER_CYCLE;
	localparam int CYC_W   = (DIV_CYC > 1) ? $clog2(DIV_CYC) : 1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIV,
		ST_EMIT
	} state_t;

	state_t             state_q;
	logic [DIV_W-1:0]   quo_q;
	logic [RADIX_W-1:0] rem_q;
	logic [RADIX_W-1:0] base_q;
	logic [CYC_W-1:0]   cyc_q;
	logic [CNT_W-1:0]   count_q;
	logic [ADDR_W-1:0]  idx_q;
	logic [DIGIT_W-1:0] rd_data_q;
	logic               rd_vld_q;
	logic               rd_last_q;

	logic [DIGIT_W-1:0] store [STORE_DEPTH];

	logic [DIV_W-1:0]   quo_nx;
	logic [RADIX_W-1:0] rem_nx;
	logic               wr_en;
	logic [ADDR_W-1:0]  wr_addr;
	logic [DIGIT_W-1:0] wr_data;
	logic               in_zero;
	logic [RADIX_W-1:0] in_base;
	logic [VALUE_WIDTH-1:0] in_value;

	assign {in_zero, in_base, in_value} = pop_data;

	// Eight restoring-division steps on the narrow remainder
	always_comb begin
		quo_nx = quo_q;
		rem_nx = rem_q;
		for (int i = 0; i < STEPS_PER_CYCLE; i++) begin
			rem_nx = {rem_nx[RADIX_W-2:0], quo_nx[DIV_W-1]};
			quo_nx = {quo_nx[DIV_W-2:0], 1'b0};
			if (rem_nx >= base_q) begin
				rem_nx    = rem_nx - base_q;
				quo_nx[0] = 1'b1;
			end
		end
	end

	assign pop = (state_q == ST_IDLE) && !q_stat.empty;

	always_comb begin
		wr_en   = 1'b0;
		wr_addr = count_q[ADDR_W-1:0];
		wr_data = rem_nx[DIGIT_W-1:0];
		if (pop && in_zero) begin
			wr_en   = 1'b1;
			wr_addr = '0;
			wr_data = '0;
		end else if (state_q == ST_DIV && cyc_q == CYC_W'(DIV_CYC - 1)) begin
			wr_en = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			store[wr_addr] <= wr_data;
		end
		if (state_q == ST_EMIT) begin
			rd_data_q <= store[idx_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			quo_q     <= '0;
			rem_q     <= '0;
			base_q    <= RADIX_RESET;
			cyc_q     <= '0;
			count_q   <= '0;
			idx_q     <= '0;
			rd_vld_q  <= 1'b0;
			rd_last_q <= 1'b0;
		end else begin
			rd_vld_q  <= 1'b0;
			rd_last_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (pop) begin
						base_q  <= in_base;
						quo_q   <= DIV_W'(in_value);
						rem_q   <= '0;
						cyc_q   <= '0;
						if (in_zero) begin
							count_q <= CNT_W'(1);
							idx_q   <= '0;
							state_q <= ST_EMIT;
						end else begin
							count_q <= '0;
							state_q <= ST_DIV;
						end
					end
				end
				ST_DIV: begin
					if (cyc_q == CYC_W'(DIV_CYC - 1)) begin
						count_q <= count_q + CNT_W'(1);
						quo_q   <= quo_nx;
						rem_q   <= '0;
						cyc_q   <= '0;
						if (quo_nx == '0 || count_q == CNT_W'(STORE_DEPTH - 1)) begin
							idx_q   <= count_q[ADDR_W-1:0];
							state_q <= ST_EMIT;
						end
					end else begin
						quo_q <= quo_nx;
						rem_q <= rem_nx;
						cyc_q <= cyc_q + CYC_W'(1);
					end
				end
				ST_EMIT: begin
					rd_vld_q  <= 1'b1;
					rd_last_q <= (idx_q == '0);
					idx_q     <= idx_q - ADDR_W'(1);
					if (idx_q == '0) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign strobe    = rd_vld_q;
	assign char_code = glyph(rd_data_q);
	assign last      = rd_vld_q && rd_last_q;

endmodule

[design/integer_to_radix_digits.sv]
// ----------------------------------------------------------------------------
// integer_to_radix_digits: unsigned integer to ASCII digits
// Converts one unsigned value per item into its digits in base 2..16,
// emitted most significant first with a flag on the final digit.
// ----------------------------------------------------------------------------
// An item is taken on a clock edge with start high and busy low; only the
// low VALUE_WIDTH bits of value count. The base comes from the radix
// register (reset 10, written with radix_we); 0 and 1 act as 2, 17..31 as
// 16. Write radix only while nothing is in flight. Each digit leaves as one
// single-cycle strobe with its ASCII code ('0'-'9', 'A'-'F'); last marks the
// least significant digit, and a zero value gives the single digit '0'. The
// digits of one item come on consecutive cycles and cannot be stalled, so
// the receiver must take every strobe. The divider retires eight quotient
// bits a cycle and stores each remainder in the digit store; once all
// digits of an item are stored, they stream out of that store. The engine
// is back in idle when the last digit is presented, so it can take the next
// queued item while that digit is out. A two-entry queue in front of the
// engine lets up to two more items wait; busy is high while that queue is
// full. No clearing pass is needed after reset.
// ----------------------------------------------------------------------------
module integer_to_radix_digits
	import itrd_pkg::*;
#(
	parameter int VALUE_WIDTH = ITRD_VALUE_WIDTH
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	output logic                     busy,
	input  logic [VALUE_FIELD_W-1:0] value,
	input  logic                     radix_we,
	input  logic [RADIX_W-1:0]       radix_wdata,
	output logic                     strobe,
	output logic [CHAR_W-1:0]        char_code,
	output logic                     last
);

	localparam int CMD_W = VALUE_WIDTH + RADIX_W + 1;

	q_stat_t          q_stat;
	logic             push;
	logic             pop;
	logic [CMD_W-1:0] push_data;
	logic [CMD_W-1:0] pop_data;

	// Accept and classify: saturate base, mask value, flag zero
	itrd_front #(
		.VALUE_WIDTH(VALUE_WIDTH)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.value      (value),
		.radix_we   (radix_we),
		.radix_wdata(radix_wdata),
		.q_stat     (q_stat),
		.busy       (busy),
		.push       (push),
		.push_data  (push_data)
	);

	// Hold classified items until the engine is free
	itrd_queue #(
		.WIDTH(CMD_W)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_data(push_data),
		.pop      (pop),
		.pop_data (pop_data),
		.q_stat   (q_stat)
	);

	// Divide, store digits, stream them out
	itrd_back #(
		.VALUE_WIDTH(VALUE_WIDTH)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_stat   (q_stat),
		.pop_data (pop_data),
		.pop      (pop),
		.strobe   (strobe),
		.char_code(char_code),
		.last     (last)
	);

endmodule

[design/itrd_checker.sv]
// ----------------------------------------------------------------------------
// itrd_checker: port-level checks
// Watches the converter's ports for digit codes, run shape and occupancy.
// ----------------------------------------------------------------------------
module itrd_checker
	import itrd_pkg::*;
(
	input logic              clk,
	input logic              arst_n,
	input logic              start,
	input logic              busy,
	input logic              strobe,
	input logic [CHAR_W-1:0] char_code,
	input logic              last
);

	logic [2:0] open_q;
	logic       acc;
	logic       done;

	assign acc  = start && !busy;
	assign done = strobe && last;

	// Track items taken but not yet finished
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			open_q <= '0;
		end else begin
			open_q <= open_q + 3'(acc) - 3'(done);
		end
	end

	a_code: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> ((char_code >= 7'h30 && char_code <= 7'h39) ||
		            (char_code >= 7'h41 && char_code <= 7'h46)))
		else $error("digit code outside 0-9 and A-F");

	a_run: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && !last |=> strobe)
		else $error("digit run broken before last");

	a_owner: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> open_q != '0)
		else $error("digit with no item in flight");

	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> open_q >= 3'd2)
		else $error("busy with fewer than two items in flight");

	a_bound: assert property (@(posedge clk) disable iff (!arst_n)
		open_q <= 3'd3)
		else $error("more items in flight than the queue and engine hold");

endmodule

bind integer_to_radix_digits itrd_checker u_itrd_checker (.*);

[verif/tb_integer_to_radix_digits.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_integer_to_radix_digits: self-checking bench for the radix converter
// Drives values through the start/busy handshake under several radix
// settings. Every digit strobe is checked against a digit queue that is
// filled when each item is accepted, from typed strings or from a
// behavioral divider.
// ----------------------------------------------------------------------------
module tb_integer_to_radix_digits;
	import itrd_pkg::*;

	localparam int                     DUT_VALUE_W = ITRD_VALUE_WIDTH;
	localparam logic [VALUE_FIELD_W-1:0] VALUE_MASK =
		(DUT_VALUE_W >= 64) ? {VALUE_FIELD_W{1'b1}} : ((64'd1 << DUT_VALUE_W) - 64'd1);
	localparam logic [CHAR_W-1:0] ASCII_ZERO = 7'h30;
	localparam logic [CHAR_W-1:0] ASCII_A    = 7'h41;
	localparam logic [VALUE_FIELD_W-1:0] ALL_ONES = {VALUE_FIELD_W{1'b1}};

	// Cycles to hold after the last digit before touching the radix or ending
	localparam int DRAIN_CYCLES  = 20;
	localparam int RANDOM_PHASES = 8;
	localparam int PHASE_ITEMS   = 52;

	// One digit as it should appear on the result ports
	typedef struct packed {
		logic [CHAR_W-1:0] code;
		logic              last;
	} digit_t;

	// Directed stimulus: radix to run with, and the value to convert
	typedef struct packed {
		logic [RADIX_W-1:0]       radix;
		logic [VALUE_FIELD_W-1:0] value;
	} dir_row_t;

	localparam int DIR_N = 22;

	localparam dir_row_t DIR_ROWS [DIR_N] = '{
		'{5'd10, 64'd0},
		'{5'd10, 64'd1},
		'{5'd10, 64'd9},
		'{5'd10, 64'd10},
		'{5'd10, 64'hFFFF_FFFF_FFFF_FFFF},
		'{5'd16, 64'd15},
		'{5'd16, 64'd0},
		'{5'd16, 64'hFFFF_FFFF_FFFF_FFFF},
		'{5'd16, 64'h0123_4567_89AB_CDEF},
		'{5'd2,  64'd5},
		'{5'd2,  64'hFFFF_FFFF_FFFF_FFFF},
		'{5'd2,  64'h8000_0000_0000_0000},
		'{5'd0,  64'd6},
		'{5'd1,  64'd7},
		'{5'd31, 64'd255},
		'{5'd17, 64'd4096},
		'{5'd8,  64'hFFFF_FFFF_FFFF_FFFF},
		'{5'd3,  64'hFFFF_FFFF_FFFF_FFFF},
		'{5'd7,  64'hDEAD_BEEF_CAFE_F00D},
		'{5'd15, 64'h5555_5555_5555_5555},
		'{5'd12, 64'h0000_0000_0000_0144},
		'{5'd10, 64'h0000_0000_FFFF_FFFF}
	};

	// Expected text per directed row; an empty string means use the divider
	string dir_text [DIR_N] = '{
		"0",
		"1",
		"9",
		"10",
		"18446744073709551615",
		"F",
		"0",
		"FFFFFFFFFFFFFFFF",
		"123456789ABCDEF",
		"101",
		"",
		"",
		"110",
		"111",
		"FF",
		"1000",
		"1777777777777777777777",
		"",
		"",
		"",
		"230",
		"4294967295"
	};

	logic                     clk;
	logic                     arst_n;
	logic                     start;
	logic                     busy;
	logic [VALUE_FIELD_W-1:0] value;
	logic                     radix_we;
	logic [RADIX_W-1:0]       radix_wdata;
	logic                     strobe;
	logic [CHAR_W-1:0]        char_code;
	logic                     last;

	// Bench copy of the radix register and the digits still to come
	logic [RADIX_W-1:0] radix_shadow;
	digit_t             pending_digits [$];

	int mismatches;
	int items_sent;
	int digits_seen;
	int radix_writes;

	integer_to_radix_digits #(
		.VALUE_WIDTH (DUT_VALUE_W)
	) i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.value       (value),
		.radix_we    (radix_we),
		.radix_wdata (radix_wdata),
		.strobe      (strobe),
		.char_code   (char_code),
		.last        (last)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// ASCII code of one digit value
	function automatic logic [CHAR_W-1:0] digit_glyph(input logic [3:0] d);
		if (d < 4'd10) begin
			return ASCII_ZERO + CHAR_W'(d);
		end
		return ASCII_A + CHAR_W'(d) - CHAR_W'(10);
	endfunction

	// Divide the value down by the current base and queue its digits, most
	// significant first, with last on the final one
	task automatic convert_to_digits(input logic [VALUE_FIELD_W-1:0] v);
		logic [VALUE_FIELD_W-1:0] rem;
		logic [VALUE_FIELD_W-1:0] base;
		logic [3:0]               store [STORE_DEPTH];
		int                       n;
		int                       k;
		digit_t                   d;
		// Saturate the base into two to sixteen
		if (radix_shadow < RADIX_MIN) begin
			base = VALUE_FIELD_W'(RADIX_MIN);
		end else if (radix_shadow > RADIX_MAX) begin
			base = VALUE_FIELD_W'(RADIX_MAX);
		end else begin
			base = VALUE_FIELD_W'(radix_shadow);
		end
		rem = v & VALUE_MASK;
		n = 0;
		do begin
			store[n] = 4'(rem % base);
			n++;
			rem = rem / base;
		end while (rem != 0 && n < STORE_DEPTH);
		for (k = 0; k < n; k++) begin
			d.code = digit_glyph(store[n - 1 - k]);
			d.last = (k == n - 1);
			pending_digits.push_back(d);
		end
	endtask

	// Queue digits straight from a typed string
	task automatic queue_text(input string text);
		int     i;
		digit_t d;
		for (i = 0; i < text.len(); i++) begin
			d.code = CHAR_W'(text[i]);
			d.last = (i == text.len() - 1);
			pending_digits.push_back(d);
		end
	endtask

	// Present one item from a falling edge and hold it until the handshake
	// takes it; return at the following falling edge with start still high
	task automatic send_item(input logic [VALUE_FIELD_W-1:0] v, input string text);
		start = 1'b1;
		value = v;
		do begin
			@(posedge clk);
		end while (busy);
		// Fill the digit queue at the accepting edge
		if (text.len() != 0) begin
			queue_text(text);
		end else begin
			convert_to_digits(v);
		end
		items_sent++;
		@(negedge clk);
	endtask

	// Drop start for a burst of cycles, with noise on the value bus
	task automatic idle_burst(input int cycles);
		start = 1'b0;
		repeat (cycles) begin
			value = {$urandom, $urandom};
			@(negedge clk);
		end
	endtask

	// Wait for every queued digit, let the engine settle, then write radix
	task automatic write_radix(input logic [RADIX_W-1:0] r);
		start = 1'b0;
		while (pending_digits.size() != 0) begin
			@(negedge clk);
		end
		repeat (DRAIN_CYCLES) @(negedge clk);
		radix_we    = 1'b1;
		radix_wdata = r;
		@(negedge clk);
		radix_we     = 1'b0;
		radix_shadow = r;
		radix_writes++;
	endtask

	// Mix of value shapes: full width, short, truncated, all ones, one bit, zero
	function automatic logic [VALUE_FIELD_W-1:0] random_value();
		logic [VALUE_FIELD_W-1:0] v;
		v = {$urandom, $urandom};
		case ($urandom_range(0, 5))
			0: begin
				return v;
			end
			1: begin
				return VALUE_FIELD_W'($urandom_range(0, 255));
			end
			2: begin
				return v >> $urandom_range(0, 63);
			end
			3: begin
				return ALL_ONES >> $urandom_range(0, 63);
			end
			4: begin
				return VALUE_FIELD_W'(1) << $urandom_range(0, 63);
			end
			default: begin
				return ($urandom_range(0, 1) == 0) ? '0 : ALL_ONES;
			end
		endcase
	endfunction

	// Check every strobe against the oldest queued digit
	always @(posedge clk) begin
		digit_t exp_d;
		if (arst_n && strobe) begin
			digits_seen++;
			if (pending_digits.size() == 0) begin
				$display("%0t: unexpected digit: expected none, actual char_code %h last %b",
					$time, char_code, last);
				mismatches++;
			end else begin
				exp_d = pending_digits.pop_front();
				if (char_code !== exp_d.code) begin
					$display("%0t: char_code expected %h actual %h",
						$time, exp_d.code, char_code);
					mismatches++;
				end
				if (last !== exp_d.last) begin
					$display("%0t: last expected %b actual %b", $time, exp_d.last, last);
					mismatches++;
				end
			end
		end
	end

	// Main sequence: reset, directed table, random phases, drain
	initial begin
		int                 row;
		int                 phase;
		int                 n;
		int                 idle_pct;
		logic [RADIX_W-1:0] r;

		start        = 1'b0;
		value        = '0;
		radix_we     = 1'b0;
		radix_wdata  = '0;
		arst_n       = 1'b0;
		radix_shadow = RADIX_RESET;
		mismatches   = 0;
		items_sent   = 0;
		digits_seen  = 0;
		radix_writes = 0;

		// Hold reset, then release it away from the rising edge
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Walk the directed table; rewrite radix only where the row changes it
		for (row = 0; row < DIR_N; row++) begin
			if (DIR_ROWS[row].radix != radix_shadow) begin
				write_radix(DIR_ROWS[row].radix);
			end
			send_item(DIR_ROWS[row].value, dir_text[row]);
		end

		// Random phases: the first ones pin the base extremes, the last one
		// runs without idling
		for (phase = 0; phase < RANDOM_PHASES; phase++) begin
			case (phase)
				0: begin
					r = RADIX_MIN;
				end
				1: begin
					r = RADIX_MAX;
				end
				2: begin
					r = '0;
				end
				3: begin
					r = '1;
				end
				default: begin
					if ($urandom_range(0, 3) == 0) begin
						r = RADIX_W'($urandom_range(0, 31));
					end else begin
						r = RADIX_W'($urandom_range(2, 16));
					end
				end
			endcase
			write_radix(r);
			if (phase == RANDOM_PHASES - 1) begin
				idle_pct = 0;
			end else begin
				case ($urandom_range(0, 2))
					0: idle_pct = 0;
					1: idle_pct = 25;
					default: idle_pct = 60;
				endcase
			end
			for (n = 0; n < PHASE_ITEMS; n++) begin
				if ($urandom_range(0, 99) < idle_pct) begin
					idle_burst($urandom_range(1, 9));
				end
				send_item(random_value(), "");
			end
		end

		// Drop start and let the last digits drain
		start = 1'b0;
		while (pending_digits.size() != 0) begin
			@(negedge clk);
		end
		repeat (DRAIN_CYCLES) @(negedge clk);

		$display("Converted %0d items into %0d checked digits over %0d radix settings",
			items_sent, digits_seen, radix_writes + 1);
		if (mismatches == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

	// Guard against a hung handshake
	initial begin
		#12_000_000;
		$display("Timeout with %0d digits still expected", pending_digits.size());
		$display("Mismatches found");
		$finish;
	end

endmodule

[files.f]
design/itrd_pkg.sv
design/itrd_front.sv
design/itrd_queue.sv
design/itrd_back.sv
design/integer_to_radix_digits.sv
design/itrd_checker.sv
verif/tb_integer_to_radix_digits.sv
